FILE: src/strs_pkg.sv
// Shared types and constants for the segment tree range sum core.
package strs_pkg;
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;
	localparam int DATA_W = 32;
	localparam int IDX_W = 6;

	// Request that walks down the cell chain.
	typedef struct packed {
		logic              valid;
		logic              command;
		logic [IDX_W-1:0]  elem_index;
		logic [DATA_W-1:0] new_value;
		logic [IDX_W-1:0]  range_start;
		logic [IDX_W-1:0]  range_end;
		logic [DATA_W-1:0] acc;
	} strs_req_t;
endpackage

FILE: src/segment_tree_range_sum_core.sv
// Top level of the range sum store: a chain of element cells with a two-entry result buffer.
// A request is registered in every cell of the chain; a query's result then lands in the
// output register, or in the spare register while the output is stalled. One request in
// flight, taken again once the last has left the chain; a full result buffer stalls input.
// Reset clears every stored element and the result buffer at once; no clearing pass is needed.
// Writes beyond the element count are dropped; empty or out-of-bounds queries return zero.
module segment_tree_range_sum_core #(
	parameter int LEAF_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// From bit 0: command, elem_index[6], new_value[32], range_start[6], range_end[6], pad.
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// From bit 0: range_sum[32].
	output logic [31:0] m_tdata
);
	import strs_pkg::*;

	// Request chain: entry 0 feeds the first cell.
	strs_req_t chain [LEAF_COUNT+1];
	strs_req_t head_req;
	logic      busy_q;
	logic      out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic      spare_valid_q;
	logic [DATA_W-1:0] spare_data_q;
	logic      res_push;
	logic      res_pop;
	logic      qry_ok;
	strs_req_t tail;

	// One request in flight. The spare result register must be free so that the
	// result always has a place to land, even while the output register is stalled.
	assign s_tready = !busy_q && !spare_valid_q;

	assign qry_ok = (s_tdata[44:39] <= s_tdata[50:45])
		&& (32'(s_tdata[50:45]) < 32'(LEAF_COUNT));

	always_comb begin
		head_req.valid       = s_tvalid && s_tready;
		head_req.command     = s_tdata[0];
		head_req.elem_index  = s_tdata[6:1];
		head_req.new_value   = s_tdata[38:7];
		// An invalid query is turned into an empty range so nothing accumulates.
		head_req.range_start = qry_ok ? s_tdata[44:39] : IDX_W'(1);
		head_req.range_end   = qry_ok ? s_tdata[50:45] : IDX_W'(0);
		head_req.acc         = '0;
	end

	assign chain[0] = head_req;

	for (genvar g = 0; g < LEAF_COUNT; g++) begin : g_cell
		strs_cell #(.CELL_INDEX(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.req_in (chain[g]),
			.req_out(chain[g+1])
		);
	end

	assign tail = chain[LEAF_COUNT];

	// A query leaving the chain pushes a result; a master handshake pops one.
	assign res_push = tail.valid && tail.command == CMD_QUERY;
	assign res_pop  = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			if (head_req.valid) begin
				busy_q <= 1'b1;
			end else if (tail.valid) begin
				busy_q <= 1'b0;
			end
			if (res_pop) begin
				// The spare result moves up, or the output empties unless refilled.
				if (spare_valid_q) begin
					spare_valid_q <= 1'b0;
				end else if (!res_push) begin
					out_valid_q <= 1'b0;
				end
			end else if (res_push) begin
				if (out_valid_q) begin
					spare_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push && (!out_valid_q || res_pop)) begin
			out_data_q <= tail.acc;
		end else if (res_pop && spare_valid_q) begin
			out_data_q <= spare_data_q;
		end
		if (res_push && out_valid_q && !res_pop) begin
			spare_data_q <= tail.acc;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// A request leaving the chain must find the spare register empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !spare_valid_q)
		else $error("result overwrote a pending result");
	// The spare register only holds a result behind the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> out_valid_q)
		else $error("spare result without an output result");
	// Nothing is accepted while a request walks the chain.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !head_req.valid)
		else $error("request accepted while busy");
	// A request leaving the chain means the block was busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> busy_q)
		else $error("request left chain while idle");
endmodule

FILE: src/strs_cell.sv
// One element cell: holds one stored value and folds it into a passing request.
module strs_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  strs_pkg::strs_req_t req_in,
	output strs_pkg::strs_req_t req_out
);
	import strs_pkg::*;

	logic [DATA_W-1:0] value_q;
	logic              in_range;
	logic              hit;
	strs_req_t         req_next;
	strs_req_t         req_s1;

	assign in_range = (32'(req_in.range_start) <= 32'(CELL_INDEX))
		&& (32'(req_in.range_end) >= 32'(CELL_INDEX));
	assign hit = req_in.valid && (req_in.command == CMD_WRITE)
		&& (32'(req_in.elem_index) == 32'(CELL_INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (hit) begin
			value_q <= req_in.new_value;
		end
	end

	// A query picks up this cell's value when the cell lies inside its range.
	always_comb begin
		req_next = req_in;
		if (req_in.command == CMD_QUERY && in_range) begin
			req_next.acc = req_in.acc + value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else begin
			req_s1 <= req_next;
		end
	end

	assign req_out = req_s1;
endmodule

FILE: test/tb_segment_tree_range_sum_core.sv
// Self-checking testbench for the segment tree range sum core.
module tb_segment_tree_range_sum_core;
	timeunit 1ns;
	timeprecision 1ps;
	import strs_pkg::*;

	localparam int LEAVES = 64;
	localparam int RANDOM_REQUESTS = 750;
	localparam longint CYCLE_LIMIT = 2_000_000;

	// One request as it travels on the slave side; the last member sits in bit 0.
	typedef struct packed {
		logic [IDX_W-1:0]  range_end;
		logic [IDX_W-1:0]  range_start;
		logic [DATA_W-1:0] new_value;
		logic [IDX_W-1:0]  elem_index;
		logic              command;
	} request_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// From bit 0: command, elem_index[6], new_value[32], range_start[6], range_end[6], pad.
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// From bit 0: range_sum[32].
	logic [31:0] m_tdata;

	segment_tree_range_sum_core #(.LEAF_COUNT(LEAVES)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Shadow copy of the element array; a flat array is enough to predict sums.
	logic [DATA_W-1:0] element_mirror [LEAVES];
	request_t          pending_requests [$];
	logic [DATA_W-1:0] expected_sums [$];
	request_t          accepted_req;
	int                error_count;
	int                sums_checked;
	int                writes_sent;
	longint            cycle_count;
	logic              hold_sender;

	// Apply one accepted request to the shadow and queue the sum a query yields.
	function automatic void predict_request(input request_t req);
		logic [DATA_W-1:0] total;
		total = '0;
		if (req.command == CMD_WRITE) begin
			if (req.elem_index < LEAVES)
				element_mirror[req.elem_index] = req.new_value;
		end else begin
			if (req.range_start <= req.range_end && req.range_end < LEAVES)
				for (int i = int'(req.range_start); i <= int'(req.range_end); i++)
					total += element_mirror[i];
			expected_sums.push_back(total);
		end
	endfunction

	function automatic request_t make_write(input int idx, input logic [31:0] value);
		request_t req;
		req = '0;
		req.command = CMD_WRITE;
		req.elem_index = IDX_W'(idx);
		req.new_value = value;
		req.range_start = IDX_W'($urandom);
		req.range_end = IDX_W'($urandom);
		return req;
	endfunction

	function automatic request_t make_query(input int first, input int last);
		request_t req;
		req = '0;
		req.command = CMD_QUERY;
		req.elem_index = IDX_W'($urandom);
		req.new_value = $urandom;
		req.range_start = IDX_W'(first);
		req.range_end = IDX_W'(last);
		return req;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: presents queued requests with random gaps between them.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				accepted_req = pending_requests.pop_front();
				predict_request(accepted_req);
				if (accepted_req.command == CMD_WRITE)
					writes_sent++;
				send_gap = gap_length();
			end
			if (s_tvalid && !s_tready) begin
				// Hold the request until it is taken.
			end else if (send_gap > 0 || hold_sender || pending_requests.size() == 0) begin
				if (send_gap > 0)
					send_gap--;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= {5'b0, pending_requests[0]};
			end
		end
	end

	// Monitor: random back pressure and comparison against the oldest prediction.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_sums.size() == 0) begin
					$error("range_sum: unexpected result %0d", $signed(m_tdata));
					error_count++;
				end else begin
					if (m_tdata !== expected_sums[0]) begin
						$error("range_sum: expected %0d, actual %0d",
							$signed(expected_sums[0]), $signed(m_tdata));
						error_count++;
					end
					void'(expected_sums.pop_front());
					sums_checked++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = gap_length();
				m_tready <= (stall_left == 0);
			end
		end
	end

	// Watchdog on a cycle counter.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int first;
		int last;
		int burst;
		error_count = 0;
		sums_checked = 0;
		writes_sent = 0;
		cycle_count = 0;
		hold_sender = 1'b0;
		foreach (element_mirror[i]) element_mirror[i] = '0;

		// Directed part: freshly reset store, field extremes and wrapping sums.
		pending_requests.push_back(make_query(0, 63));
		pending_requests.push_back(make_write(0, 32'h7FFF_FFFF));
		pending_requests.push_back(make_write(63, 32'h7FFF_FFFF));
		pending_requests.push_back(make_query(0, 63));           // wraps past max
		pending_requests.push_back(make_write(31, 32'h8000_0000));
		pending_requests.push_back(make_write(32, 32'hFFFF_FFFF));
		pending_requests.push_back(make_query(31, 32));          // wraps past min
		pending_requests.push_back(make_query(63, 63));
		pending_requests.push_back(make_query(0, 0));
		pending_requests.push_back(make_query(40, 39));          // empty range
		pending_requests.push_back(make_query(63, 0));           // empty range
		pending_requests.push_back(make_write(0, 32'h0000_0005)); // overwrite
		pending_requests.push_back(make_query(0, 31));
		pending_requests.push_back(make_query(1, 62));
		pending_requests.push_back(make_write(17, 32'hAAAA_5555));
		pending_requests.push_back(make_write(46, 32'h5555_AAAA));
		pending_requests.push_back(make_query(17, 46));
		pending_requests.push_back(make_query(0, 63));
		// Every write index fits the 64-entry store, so no write is out of range here.

		wait (pending_requests.size() == 0);
		// Sender holds off until every query so far has been answered.
		hold_sender = 1'b1;
		wait (expected_sums.size() == 0);
		hold_sender = 1'b0;

		// Random part: bursts of randomly mixed writes and queries over random ranges.
		for (int n = 0; n < RANDOM_REQUESTS; n += burst) begin
			burst = $urandom_range(1, 8);
			for (int k = 0; k < burst; k++) begin
				if ($urandom_range(0, 99) < 50) begin
					pending_requests.push_back(
						make_write($urandom_range(0, 63), random_value()));
				end else begin
					first = $urandom_range(0, 63);
					last = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
						: $urandom_range(first, 63);
					pending_requests.push_back(make_query(first, last));
				end
			end
			while (pending_requests.size() > 16) @(posedge clk);
		end
		wait (pending_requests.size() == 0);
		wait (expected_sums.size() == 0);
		repeat (LEAVES + 10) @(posedge clk);

		$display("Checked %0d range sums over %0d element writes in %0d cycles.",
			sums_checked, writes_sent, cycle_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
